@@ rtl/stream_rank_multiset_macros.svh @@
// Assertion helpers for the rank multiset block.
// Each macro checks on the rising edge of clk and is off while rst is high.
`ifndef STREAM_RANK_MULTISET_MACROS_SVH
`define STREAM_RANK_MULTISET_MACROS_SVH

// Same-cycle implication.
`define SRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rank multiset check failed");

// Next-cycle implication.
`define SRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rank multiset check failed");

`endif

@@ rtl/srm_pkg.sv @@
package srm_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned RANK_W = 7;
  localparam int unsigned RANK_MAX = 63;
  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic operation;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic signed [RANK_W-1:0] rank;
    logic found;
    logic overflow;
  } result_t;

  // Work item travelling down the cell chain.
  typedef struct packed {
    logic valid;
    logic operation;
    logic [31:0] key;          // order-mapped: unsigned compare matches signed order
    logic [CNT_W-1:0] count;   // store fill seen when the request entered
    logic overflow;
    logic [CNT_W-1:0] at_most;
    logic present;
  } token_t;

endpackage

@@ rtl/srm_cell.sv @@
module srm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [srm_pkg::IDX_W-1:0] position,
  input  srm_pkg::token_t           tok_in,
  output srm_pkg::token_t           tok_out
);
  import srm_pkg::*;

  logic [31:0] slot;
  token_t      tok_next;
  logic        occupied;
  logic        write;

  always_comb begin
    tok_next = tok_in;
    occupied = CNT_W'(position) < tok_in.count;
    write = tok_in.valid && (tok_in.operation == OP_INSERT) && !tok_in.overflow &&
            (CNT_W'(position) == tok_in.count);
    if (tok_in.valid && (tok_in.operation == OP_QUERY) && occupied) begin
      if (slot <= tok_in.key) begin
        tok_next.at_most = tok_in.at_most + 1'b1;
      end
      if (slot == tok_in.key) begin
        tok_next.present = 1'b1;
      end
    end
  end

  // Hold the stored value; an insert claims the first free slot.
  always_ff @(posedge clk) begin
    if (advance && write) begin
      slot <= tok_in.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ rtl/stream_rank_multiset.sv @@
// Rank multiset: keeps up to CAPACITY (64) signed 32-bit values and answers, per request,
// either an insert (result: overflow set if the store was full and the value dropped) or
// a rank query (result: count of stored values <= key, minus one, with found set, or
// rank -1 and found clear when the key is absent). One request enters per cycle unless the
// result stalls, and every request gives exactly one result, in order. The request walks
// a chain of CAPACITY compare cells, one cell per cycle, then lands in the result
// register. Each cell holds one stored value; a later request always trails an earlier
// insert down the chain, so it sees that insert. A stalled result freezes the whole chain.
module stream_rank_multiset (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  srm_pkg::request_t  request,
  output logic               result_valid,
  input  logic               result_stall,
  output srm_pkg::result_t   result
);
  import srm_pkg::*;

  `include "stream_rank_multiset_macros.svh"

  logic             advance;
  logic             accept;
  logic             full;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] stored_count_next;
  token_t           chain [CAPACITY+1];
  token_t           last;
  result_t          result_next;
  logic [CNT_W-1:0] rank_raw;

  // Advance the chain whenever the result register is free or being drained.
  assign advance = !result_valid || !result_stall;
  assign request_stall = !advance;
  assign accept = request_valid && advance;
  assign full = stored_count == CNT_W'(CAPACITY);

  // Build the entry token: snapshot the fill so each cell knows if it is occupied.
  always_comb begin
    chain[0].valid = request_valid;
    chain[0].operation = request.operation;
    chain[0].key = request.value ^ SIGN_FLIP;
    chain[0].count = stored_count;
    chain[0].overflow = (request.operation == OP_INSERT) && full;
    chain[0].at_most = '0;
    chain[0].present = 1'b0;
  end

  always_comb begin
    stored_count_next = stored_count;
    if (accept && (request.operation == OP_INSERT) && !full) begin
      stored_count_next = stored_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
    end else begin
      stored_count <= stored_count_next;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    srm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .position (IDX_W'(g)),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end

  assign last = chain[CAPACITY];

  // Format the result; saturate rank at the field's top when capacity is large.
  always_comb begin
    rank_raw = last.at_most - 1'b1;
    result_next.found = 1'b0;
    result_next.overflow = 1'b0;
    result_next.rank = '0;
    if (last.operation == OP_INSERT) begin
      result_next.overflow = last.overflow;
    end else if (last.present) begin
      result_next.found = 1'b1;
      if (32'(rank_raw) > RANK_MAX) begin
        result_next.rank = RANK_W'(RANK_MAX);
      end else begin
        result_next.rank = RANK_W'(rank_raw);
      end
    end else begin
      result_next.rank = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // Fill never passes capacity.
  `SRM_ASSERT_NOW(a_count_bound, 1'b1, stored_count <= CNT_W'(CAPACITY))
  // A found key carries a real rank and no overflow.
  `SRM_ASSERT_NOW(a_found_rank, result_valid && result.found, !result.overflow && result.rank >= 0)
  // An insert into a full store leaves the fill unchanged.
  `SRM_ASSERT_NEXT(a_drop_holds, accept && chain[0].overflow, full)
  // A stall from the result side blocks new requests.
  `SRM_ASSERT_NOW(a_stall_blocks, result_valid && result_stall, request_stall)

endmodule

@@ tb/stream_rank_multiset_checker.sv @@
`timescale 1ns / 100ps

module stream_rank_multiset_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  input  logic              request_stall,
  input  srm_pkg::request_t request,
  input  logic              result_valid,
  input  logic              result_stall,
  input  srm_pkg::result_t  result,
  output int                fail_count,
  output int                pending
);

  srm_pkg::result_t   rank_answers[$];
  logic signed [31:0] multiset_values[srm_pkg::CAPACITY];
  int unsigned        multiset_size;

  initial begin
    fail_count = 0;
    pending = 0;
    multiset_size = 0;
  end

  // Apply one request to the shadow multiset and return the answer it must give.
  function automatic srm_pkg::result_t update_multiset(srm_pkg::request_t req);
    srm_pkg::result_t answer;
    int unsigned      at_most;
    logic             present;
    int               r;
    answer = '0;
    at_most = 0;
    present = 1'b0;
    if (req.operation == srm_pkg::OP_INSERT) begin
      if (multiset_size < srm_pkg::CAPACITY) begin
        multiset_values[multiset_size] = req.value;
        multiset_size++;
      end else begin
        answer.overflow = 1'b1;
      end
    end else begin
      for (int i = 0; i < multiset_size; i++) begin
        if (multiset_values[i] <= req.value) at_most++;
        if (multiset_values[i] == req.value) present = 1'b1;
      end
      if (present) begin
        r = (at_most - 1 > srm_pkg::RANK_MAX) ? srm_pkg::RANK_MAX : at_most - 1;
        answer.rank = r[srm_pkg::RANK_W-1:0];
        answer.found = 1'b1;
      end else begin
        answer.rank = '1;
      end
    end
    return answer;
  endfunction

  always @(posedge clk) begin
    srm_pkg::result_t want;
    if (rst) begin
      multiset_size = 0;
      rank_answers.delete();
    end else begin
      // Check the outgoing answer before queuing a new one.
      if (result_valid && !result_stall) begin
        if (rank_answers.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: rank %0d found %0b overflow %0b",
                     result.rank, result.found, result.overflow);
          fail_count++;
        end else begin
          want = rank_answers.pop_front();
          if (result.rank !== want.rank || result.found !== want.found ||
              result.overflow !== want.overflow) begin
            if (fail_count < 10)
              $display("mismatch: want rank %0d found %0b ovf %0b, got rank %0d found %0b ovf %0b",
                       want.rank, want.found, want.overflow,
                       result.rank, result.found, result.overflow);
            fail_count++;
          end
        end
      end
      if (request_valid && !request_stall)
        rank_answers.push_back(update_multiset(request));
    end
    pending = rank_answers.size();
  end

endmodule

@@ tb/stream_rank_multiset_tb.sv @@
`timescale 1ns / 100ps

module stream_rank_multiset_tb;

  localparam int PHASE_ITEMS = 460;
  localparam int DRAIN_CYCLES = srm_pkg::CAPACITY + 8;

  // Idle and stall percentages per random phase: none, sender, receiver, both lightly.
  localparam int IDLE_PCT[4]  = '{0, 45, 0, 6};
  localparam int STALL_PCT[4] = '{0, 0, 45, 6};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              request_valid = 1'b0;
  logic              request_stall;
  srm_pkg::request_t request = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  srm_pkg::result_t  result;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;

  // Values sent as inserts; used to aim queries at keys that are likely stored.
  logic signed [31:0] inserted_keys[$];

  always #2 clk = ~clk;

  stream_rank_multiset dut (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request      (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  stream_rank_multiset_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request      (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Stall the result side at random; the chain freezes behind a stall.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Present one request at a falling edge, after random idle cycles, and
  // hold it until a rising edge sees it accepted.
  task automatic send_request(input logic op, input logic signed [31:0] key);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      request_valid <= 1'b0;
      @(negedge clk);
    end
    request_valid <= 1'b1;
    request <= '{operation: op, value: key};
    do @(posedge clk); while (request_stall);
  endtask

  initial begin
    logic               op;
    logic signed [31:0] key;
    int                 pick;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: query the empty store, insert the extremes and a duplicate,
    // then hit each stored key and the absent keys right beside the extremes.
    send_request(srm_pkg::OP_QUERY, 32'sd0);
    send_request(srm_pkg::OP_INSERT, 32'sd0);
    send_request(srm_pkg::OP_INSERT, 32'sh8000_0000);
    send_request(srm_pkg::OP_INSERT, 32'sh7fff_ffff);
    send_request(srm_pkg::OP_INSERT, 32'sd0);
    send_request(srm_pkg::OP_INSERT, -32'sd1);
    send_request(srm_pkg::OP_INSERT, 32'sd5);
    send_request(srm_pkg::OP_QUERY, 32'sd0);
    send_request(srm_pkg::OP_QUERY, 32'sh8000_0000);
    send_request(srm_pkg::OP_QUERY, 32'sh7fff_ffff);
    send_request(srm_pkg::OP_QUERY, -32'sd1);
    send_request(srm_pkg::OP_QUERY, 32'sd1);
    send_request(srm_pkg::OP_QUERY, 32'sh8000_0001);
    send_request(srm_pkg::OP_QUERY, 32'sh7fff_fffe);
    send_request(srm_pkg::OP_QUERY, 32'sd5);
    inserted_keys = '{32'sd0, 32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd5};

    // Random phases. About one request in five is an insert, so the store
    // fills during the first phase; later inserts all hit the full store.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          op = srm_pkg::OP_INSERT;
          case ($urandom_range(0, 3))
            0: begin
              case ($urandom_range(0, 3))
                0: key = 32'sh8000_0000;
                1: key = 32'sh7fff_ffff;
                2: key = 32'sd0;
                default: key = -32'sd1;
              endcase
            end
            1: key = $signed($urandom_range(0, 16)) - 32'sd8;
            default: key = $urandom;
          endcase
          inserted_keys.push_back(key);
        end else begin
          // Aim most queries at inserted keys or their neighbors; the rest are wild.
          op = srm_pkg::OP_QUERY;
          pick = $urandom_range(0, 9);
          key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
          if (pick >= 8)
            key = $urandom;
          else if (pick >= 6)
            key = $urandom_range(0, 1) ? key + 32'sd1 : key - 32'sd1;
        end
        send_request(op, key);
      end
      // Hold off new requests until every answer of this phase is out.
      @(negedge clk);
      request_valid <= 1'b0;
      wait (pending == 0);
    end

    // Drain the chain and give any stray result time to show up.
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Bound the run far beyond the slowest legal schedule.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
